### hw/rtl/lhist_pkg.sv
// Shared types, constants and the decade bound table of the log bucket histogram.
// No dependencies; the other files except lhist_ram reference it by scoped names.
package lhist_pkg;

	localparam int DATA_W      = 64;
	localparam int IDX_W       = 7;
	localparam int STORE_DEPTH = 121;
	localparam int DECADES     = 12;
	localparam int LIN_MAX_I   = 120;
	localparam int LOG_CAP_I   = (10 * DECADES > LIN_MAX_I) ? LIN_MAX_I : 10 * DECADES;

	localparam logic [IDX_W-1:0] LINEAR_MAX  = IDX_W'(LIN_MAX_I);
	localparam logic [IDX_W-1:0] LOG_CAP     = IDX_W'(LOG_CAP_I);
	localparam logic [IDX_W-1:0] LOG_MIN_CNT = IDX_W'(10);
	localparam logic [IDX_W-1:0] DEPTH_IDX   = IDX_W'(STORE_DEPTH);

	localparam int CFG_IDX_W = 2;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 392;

	// Item operation carried in tuser
	typedef enum logic {
		OP_SAMPLE = 1'b0,
		OP_READ   = 1'b1
	} op_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOG_MODE     = 2'd0,
		CFG_BUCKET_COUNT = 2'd1,
		CFG_LIMIT        = 2'd2,
		CFG_UNUSED       = 2'd3
	} cfg_idx_t;

	// Control from the sequencer to the statistics registers
	typedef struct packed {
		logic update;
		logic clear_over;
	} stat_ctl_t;

	// Running totals as seen on the result item
	typedef struct packed {
		logic [DATA_W-1:0] count;
		logic [DATA_W-1:0] sum;
		logic [DATA_W-1:0] min_val;
		logic [DATA_W-1:0] max_val;
		logic [DATA_W-1:0] over;
	} stat_t;

	// Upper bounds: 0..10, then floor(10^(k/10))
	localparam logic [DATA_W-1:0] BOUND_TABLE [STORE_DEPTH] = '{
		64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd6, 64'd7, 64'd8, 64'd9, 64'd10,
		64'd12, 64'd15, 64'd19, 64'd25, 64'd31, 64'd39, 64'd50, 64'd63, 64'd79, 64'd100,
		64'd125, 64'd158, 64'd199, 64'd251, 64'd316, 64'd398, 64'd501, 64'd630, 64'd794,
		64'd1000,
		64'd1258, 64'd1584, 64'd1995, 64'd2511, 64'd3162, 64'd3981, 64'd5011, 64'd6309,
		64'd7943, 64'd10000,
		64'd12589, 64'd15848, 64'd19952, 64'd25118, 64'd31622, 64'd39810, 64'd50118,
		64'd63095, 64'd79432, 64'd100000,
		64'd125892, 64'd158489, 64'd199526, 64'd251188, 64'd316227,
		64'd398107, 64'd501187, 64'd630957, 64'd794328, 64'd1000000,
		64'd1258925, 64'd1584893, 64'd1995262, 64'd2511886, 64'd3162277,
		64'd3981071, 64'd5011872, 64'd6309573, 64'd7943282, 64'd10000000,
		64'd12589254, 64'd15848931, 64'd19952623, 64'd25118864, 64'd31622776,
		64'd39810717, 64'd50118723, 64'd63095734, 64'd79432823, 64'd100000000,
		64'd125892541, 64'd158489319, 64'd199526231, 64'd251188643, 64'd316227766,
		64'd398107170, 64'd501187233, 64'd630957344, 64'd794328234, 64'd1000000000,
		64'd1258925411, 64'd1584893192, 64'd1995262314, 64'd2511886431,
		64'd3162277660, 64'd3981071705, 64'd5011872336, 64'd6309573444,
		64'd7943282347, 64'd10000000000,
		64'd12589254117, 64'd15848931924, 64'd19952623149, 64'd25118864315,
		64'd31622776601, 64'd39810717055, 64'd50118723362, 64'd63095734448,
		64'd79432823472, 64'd100000000000,
		64'd125892541179, 64'd158489319246, 64'd199526231496, 64'd251188643150,
		64'd316227766016, 64'd398107170553, 64'd501187233627, 64'd630957344480,
		64'd794328234724, 64'd1000000000000
	};

endpackage

### hw/rtl/log_bucket_histogram_top.sv
// Log bucket histogram top level: sequencer, bucket counter RAM, config registers.
// Depends on lhist_pkg, lhist_ram, lhist_search, lhist_stats.
//
// Channel   Direction  Accepted when                    Carries
// s_axis    in         s_axis_tvalid & s_axis_tready    operation, sample, bucket_select
// m_axis    out        m_axis_tvalid & m_axis_tready    bucket and running totals
// cfg       in         cfg_valid & cfg_ready            register index, write data
//
// One item at a time; s_axis_tready is high only while idle. A read passes through
// ST_READ, ST_UPDATE and ST_EMIT; a sample passes through ST_SEARCH, ST_UPDATE and
// ST_EMIT, and the input then reopens in ST_IDLE. A log-mode sample stays in ST_SEARCH
// for a binary search on the bound compare (up to 7 steps); a linear one leaves at once.
// The result waits in the output register; the next item is accepted meanwhile and
// holds before its update until that result is taken. Reset clears counters at once
// through per-bucket valid bits, no clearing pass.
module log_bucket_histogram_top (
	input  logic                               clk,
	input  logic                               arst_n,
	// s_axis: tdata [63:0] sample, [70:64] bucket_select, [71] zero; tuser: operation
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [lhist_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	input  logic                               s_axis_tuser,
	// m_axis: tdata [6:0] bucket_index, [70:7] bucket_value, [134:71] sample_count,
	// [198:135] sample_sum, [262:199] minimum_value, [326:263] maximum_value,
	// [390:327] over_limit_count, [391] zero
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [lhist_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [lhist_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lhist_pkg::DATA_W-1:0]       cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_READ,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	state_t                           state_q;
	lhist_pkg::op_t                   op_q;
	logic [lhist_pkg::DATA_W-1:0]     sample_q;
	logic [lhist_pkg::IDX_W-1:0]      idx_q;
	logic [lhist_pkg::DATA_W-1:0]     val_q;
	logic [lhist_pkg::STORE_DEPTH-1:0] valid_q;

	logic                             log_mode_q;
	logic [lhist_pkg::IDX_W-1:0]      bucket_count_q;
	logic [lhist_pkg::DATA_W-1:0]     limit_q;

	logic                             in_acc;
	logic                             cfg_acc;
	logic                             out_free;
	logic                             search_start;
	logic                             search_done;
	logic [lhist_pkg::IDX_W-1:0]      search_bucket;
	logic                             in_range;
	logic                             rd_en;
	logic [lhist_pkg::IDX_W-1:0]      rd_addr;
	logic [lhist_pkg::DATA_W-1:0]     rd_data;
	logic [lhist_pkg::DATA_W-1:0]     base_val;
	logic [lhist_pkg::DATA_W-1:0]     new_val;
	logic                             wr_en;
	lhist_pkg::stat_ctl_t             stat_ctl;
	lhist_pkg::stat_t                 stats;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign out_free      = !m_axis_tvalid || m_axis_tready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_mode_q     <= 1'b0;
			bucket_count_q <= '0;
			limit_q        <= '0;
		end else if (cfg_acc) begin
			unique case (lhist_pkg::cfg_idx_t'(cfg_index))
				lhist_pkg::CFG_LOG_MODE:     log_mode_q     <= cfg_data[0];
				lhist_pkg::CFG_BUCKET_COUNT: bucket_count_q <= cfg_data[lhist_pkg::IDX_W-1:0];
				lhist_pkg::CFG_LIMIT:        limit_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// Bucket picker
	assign search_start = in_acc && (lhist_pkg::op_t'(s_axis_tuser) == lhist_pkg::OP_SAMPLE);

	lhist_search u_search (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (search_start),
		.sample       (s_axis_tdata[lhist_pkg::DATA_W-1:0]),
		.log_mode     (log_mode_q),
		.bucket_count (bucket_count_q),
		.done         (search_done),
		.bucket       (search_bucket)
	);

	// Counter RAM access
	assign in_range = idx_q < lhist_pkg::DEPTH_IDX;
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = idx_q;
		if (state_q == ST_SEARCH && search_done) begin
			rd_en   = 1'b1;
			rd_addr = search_bucket;
		end else if (state_q == ST_READ) begin
			rd_en = in_range;
		end
	end

	// Buckets never written since reset read as zero
	assign base_val = (in_range && valid_q[idx_q]) ? rd_data : '0;
	assign new_val  = base_val +
	                  lhist_pkg::DATA_W'(op_q == lhist_pkg::OP_SAMPLE);
	assign wr_en    = (state_q == ST_UPDATE) && out_free && (op_q == lhist_pkg::OP_SAMPLE);

	lhist_ram #(
		.WIDTH (lhist_pkg::DATA_W),
		.DEPTH (lhist_pkg::STORE_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (idx_q),
		.wr_data (new_val),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[idx_q] <= 1'b1;
		end
	end

	// Totals
	assign stat_ctl.update     = wr_en;
	assign stat_ctl.clear_over = cfg_acc &&
	                             (lhist_pkg::cfg_idx_t'(cfg_index) == lhist_pkg::CFG_LIMIT);

	lhist_stats u_stats (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (stat_ctl),
		.sample (sample_q),
		.limit  (limit_q),
		.stats  (stats)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			op_q          <= lhist_pkg::OP_SAMPLE;
			sample_q      <= '0;
			idx_q         <= '0;
			val_q         <= '0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						op_q     <= lhist_pkg::op_t'(s_axis_tuser);
						sample_q <= s_axis_tdata[lhist_pkg::DATA_W-1:0];
						idx_q    <= s_axis_tdata[lhist_pkg::DATA_W +: lhist_pkg::IDX_W];
						if (lhist_pkg::op_t'(s_axis_tuser) == lhist_pkg::OP_SAMPLE) begin
							state_q <= ST_SEARCH;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_SEARCH: begin
					if (search_done) begin
						idx_q   <= search_bucket;
						state_q <= ST_UPDATE;
					end
				end
				ST_READ: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					// hold until the previous result is gone so totals stay in order
					if (out_free) begin
						val_q   <= new_val;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {1'b0, stats.over, stats.max_val, stats.min_val,
						                  stats.sum, stats.count, val_q, idx_q};
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/lhist_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lhist_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 121
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### hw/rtl/lhist_search.sv
// Bucket picker: linear mapping in one step, decade table by binary search,
// one bound compare per cycle. Depends on lhist_pkg.
module lhist_search (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [lhist_pkg::DATA_W-1:0]     sample,
	input  logic                             log_mode,
	input  logic [lhist_pkg::IDX_W-1:0]      bucket_count,
	output logic                             done,
	output logic [lhist_pkg::IDX_W-1:0]      bucket
);

	logic [lhist_pkg::DATA_W-1:0] sample_q;
	logic [lhist_pkg::IDX_W-1:0]  lo_q;
	logic [lhist_pkg::IDX_W-1:0]  hi_q;
	logic [lhist_pkg::IDX_W:0]    mid_sum;
	logic [lhist_pkg::IDX_W-1:0]  mid;
	logic [lhist_pkg::IDX_W-1:0]  bnd_idx;
	logic                         below;
	logic                         log_en;
	logic [lhist_pkg::IDX_W-1:0]  n_lin;
	logic [lhist_pkg::IDX_W-1:0]  n_log;
	logic [lhist_pkg::IDX_W-1:0]  lin_pick;

	// Effective bucket counts and the linear pick
	assign log_en   = log_mode && (bucket_count > lhist_pkg::LOG_MIN_CNT);
	assign n_lin    = (bucket_count > lhist_pkg::LINEAR_MAX) ? lhist_pkg::LINEAR_MAX
	                                                          : bucket_count;
	assign n_log    = (bucket_count > lhist_pkg::LOG_CAP) ? lhist_pkg::LOG_CAP : bucket_count;
	assign lin_pick = (sample < {{(lhist_pkg::DATA_W-lhist_pkg::IDX_W){1'b0}}, n_lin})
	                  ? sample[lhist_pkg::IDX_W-1:0] : n_lin;

	// Shared compare: is the sample below the upper bound of bucket mid
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid     = mid_sum[lhist_pkg::IDX_W:1];
	assign bnd_idx = mid + lhist_pkg::IDX_W'(1);
	assign below   = sample_q < lhist_pkg::BOUND_TABLE[bnd_idx];

	assign done   = !(lo_q < hi_q);
	assign bucket = lo_q;

	// Search interval: answer lies in [lo, hi]
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= '0;
			hi_q <= '0;
		end else if (start) begin
			if (log_en) begin
				lo_q <= '0;
				hi_q <= n_log;
			end else begin
				lo_q <= lin_pick;
				hi_q <= lin_pick;
			end
		end else if (lo_q < hi_q) begin
			if (below) begin
				hi_q <= mid;
			end else begin
				lo_q <= mid + lhist_pkg::IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			sample_q <= sample;
		end
	end

endmodule

### hw/rtl/lhist_stats.sv
// Running totals: sample count, wrapping sum, minimum, maximum, over-limit count.
// Depends on lhist_pkg.
module lhist_stats (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lhist_pkg::stat_ctl_t         ctl,
	input  logic [lhist_pkg::DATA_W-1:0] sample,
	input  logic [lhist_pkg::DATA_W-1:0] limit,
	output lhist_pkg::stat_t             stats
);

	logic [lhist_pkg::DATA_W-1:0] count_q;
	logic [lhist_pkg::DATA_W-1:0] sum_q;
	logic [lhist_pkg::DATA_W-1:0] min_q;
	logic [lhist_pkg::DATA_W-1:0] max_q;
	logic [lhist_pkg::DATA_W-1:0] over_q;
	logic                         is_over;

	assign is_over = (limit != '0) && (sample > limit);

	// Update on each entered sample; limit write clears the over-limit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			min_q   <= '1;
			max_q   <= '0;
			over_q  <= '0;
		end else begin
			if (ctl.update) begin
				count_q <= count_q + lhist_pkg::DATA_W'(1);
				sum_q   <= sum_q + sample;
				if (sample < min_q) begin
					min_q <= sample;
				end
				if (sample > max_q) begin
					max_q <= sample;
				end
			end
			if (ctl.clear_over) begin
				over_q <= '0;
			end else if (ctl.update && is_over) begin
				over_q <= over_q + lhist_pkg::DATA_W'(1);
			end
		end
	end

	assign stats.count   = count_q;
	assign stats.sum     = sum_q;
	assign stats.min_val = (count_q != '0) ? min_q : '0;
	assign stats.max_val = max_q;
	assign stats.over    = over_q;

endmodule
